@@ hdl/ecu_pkg.sv @@
// ecu_pkg: shared constants, curve codes, control word and rom builders
// for the easing curve unit; no dependencies
package ecu_pkg;

	localparam int FRAC_BITS          = 16;
	localparam int SINE_TABLE_ENTRIES = 256;
	localparam int EXP_TABLE_ENTRIES  = 256;

	localparam int SINE_IDX_W = $clog2(SINE_TABLE_ENTRIES);
	localparam int EXP_IDX_W  = $clog2(EXP_TABLE_ENTRIES);

	localparam int T_W   = FRAC_BITS + 1;   // progress, one minus progress
	localparam int OUT_W = FRAC_BITS + 2;   // eased result
	localparam int EXP_W = FRAC_BITS + 2;   // exp rom entries reach two
	localparam int Z_W   = FRAC_BITS + 2;   // third product operand
	localparam int E_W   = FRAC_BITS + 4;   // scaled exponent argument
	localparam int B_W   = FRAC_BITS + 5;   // bounce abscissa times twenty-two
	localparam int D_W   = FRAC_BITS + 2;   // bounce offset magnitude
	localparam int RES_W = FRAC_BITS + 4;   // signed result before clamping
	localparam int Q30_BITS = 30;

	localparam logic [T_W-1:0] ONE  = T_W'(1) << FRAC_BITS;
	localparam logic [T_W-1:0] HALF = T_W'(1) << (FRAC_BITS - 1);

	localparam int EXP_SCALE  = 10;
	localparam int BOUNCE_MUL = 11;

	localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
	localparam logic [31:0] LN2_Q30     = 32'd744261118;
	localparam logic [31:0] BACK_C1_Q30 = 32'd1827057613;
	localparam logic [31:0] BACK_C3_Q30 = 32'd2900799437;

	typedef enum logic [3:0] {
		K_LINEAR, K_QUAD_IN, K_QUAD_OUT, K_QUAD_INOUT,
		K_CUBIC_IN, K_CUBIC_OUT, K_CUBIC_INOUT,
		K_SINE_IN, K_SINE_OUT, K_SINE_INOUT,
		K_EXPO_IN, K_EXPO_OUT, K_BOUNCE_OUT, K_BACK_OUT
	} kind_t;

	typedef enum logic [1:0] {B_FIRST, B_SECOND, B_THIRD, B_TAIL} bregion_t;

	typedef struct packed {
		logic     valid;
		kind_t    kind;
		logic     lo;      // t below one half
		logic     neg;     // t above one half
		logic     zero;    // t is zero
		logic     full;    // t is one
		logic     sfull;   // sine argument is one
		bregion_t region;
	} ctl_t;

	typedef logic [T_W-1:0]   sine_rom_t [0:SINE_TABLE_ENTRIES];
	typedef logic [EXP_W-1:0] exp_rom_t  [0:EXP_TABLE_ENTRIES];

	function automatic logic [63:0] q30_to_frac(input longint v);
		logic [63:0] w;
		w = (v < 0) ? 64'd0 : 64'(v);
		return (w + (64'd1 << (Q30_BITS - FRAC_BITS - 1))) >> (Q30_BITS - FRAC_BITS);
	endfunction

	function automatic sine_rom_t build_sine();
		sine_rom_t   r;
		logic [63:0] x, x2, term, fr;
		longint      sum;
		for (int i = 0; i <= SINE_TABLE_ENTRIES; i++) begin
			x = 64'(i) * 64'(HALF_PI_Q30) / 64'(SINE_TABLE_ENTRIES);
			x2 = (x * x) >> Q30_BITS;
			term = x;
			sum = longint'(x);
			for (int k = 1; k <= 7; k++) begin
				term = ((term * x2) >> Q30_BITS) / 64'((2 * k) * (2 * k + 1));
				if (k % 2 == 1) begin
					sum = sum - longint'(term);
				end else begin
					sum = sum + longint'(term);
				end
			end
			fr = q30_to_frac(sum);
			if (fr > 64'(ONE)) begin
				fr = 64'(ONE);
			end
			r[i] = T_W'(fr);
		end
		r[SINE_TABLE_ENTRIES] = ONE;
		return r;
	endfunction

	function automatic exp_rom_t build_exp();
		exp_rom_t    r;
		logic [63:0] y, term, sum;
		for (int i = 0; i <= EXP_TABLE_ENTRIES; i++) begin
			y = 64'(i) * 64'(LN2_Q30) / 64'(EXP_TABLE_ENTRIES);
			term = 64'd1 << Q30_BITS;
			sum = term;
			for (int k = 1; k <= 12; k++) begin
				term = ((term * y) >> Q30_BITS) / 64'(k);
				sum = sum + term;
			end
			r[i] = EXP_W'(q30_to_frac(longint'(sum)));
		end
		r[0] = EXP_W'(ONE);
		r[EXP_TABLE_ENTRIES] = EXP_W'(ONE) << 1;
		return r;
	endfunction

	localparam sine_rom_t SINE_ROM = build_sine();
	localparam exp_rom_t  EXP_ROM  = build_exp();

	// linear interpolation between neighbouring rom entries, rounded half up
	function automatic logic [EXP_W-1:0] interp(input logic [EXP_W-1:0] a,
			input logic [EXP_W-1:0] b, input logic [FRAC_BITS-1:0] fr);
		logic [EXP_W-1:0]           diff;
		logic [EXP_W+FRAC_BITS:0]   prod;
		logic [EXP_W-1:0]           step;
		diff = (b >= a) ? (b - a) : (a - b);
		prod = (EXP_W + FRAC_BITS + 1)'(diff) * (EXP_W + FRAC_BITS + 1)'(fr)
			+ ((EXP_W + FRAC_BITS + 1)'(1) << (FRAC_BITS - 1));
		step = EXP_W'(prod >> FRAC_BITS);
		return (b >= a) ? (a + step) : (a - step);
	endfunction

endpackage

@@ hdl/ecu_prep.sv @@
// ecu_prep: first pipeline stage, clamps progress and forms the operands
// of every curve; uses ecu_pkg
module ecu_prep (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         in_valid,
	input  logic [3:0]                   kind,
	input  logic [ecu_pkg::T_W-1:0]      progress,
	output ecu_pkg::ctl_t                ctl_s1,
	output logic [ecu_pkg::T_W-1:0]      t_s1,
	output logic [ecu_pkg::T_W-1:0]      x_s1,
	output logic [ecu_pkg::T_W-1:0]      y_s1,
	output logic [ecu_pkg::Z_W-1:0]      z_s1,
	output logic [ecu_pkg::T_W-1:0]      sarg_s1,
	output logic [ecu_pkg::E_W-1:0]      earg_s1,
	output logic [ecu_pkg::D_W-1:0]      dmag_s1
);

	logic [ecu_pkg::T_W-1:0] t, u, v, x, sarg;
	logic [ecu_pkg::T_W:0]   t2;
	logic [ecu_pkg::Z_W-1:0] z;
	logic [ecu_pkg::E_W-1:0] earg;
	logic [ecu_pkg::B_W-1:0] t11, t22, bd;
	logic [ecu_pkg::D_W-1:0] dmag;
	logic                    sel_u;
	ecu_pkg::ctl_t           ctl;

	function automatic logic [ecu_pkg::B_W-1:0] absdiff(input logic [ecu_pkg::B_W-1:0] a,
			input logic [ecu_pkg::B_W-1:0] b);
		return (a >= b) ? (a - b) : (b - a);
	endfunction

	function automatic logic [ecu_pkg::B_W-1:0] ones(input int n);
		return ecu_pkg::B_W'(n) << ecu_pkg::FRAC_BITS;
	endfunction

	always_comb begin
		t = (progress > ecu_pkg::ONE) ? ecu_pkg::ONE : progress;
		u = ecu_pkg::ONE - t;
		t2 = {t, 1'b0};
		ctl.valid = in_valid;
		ctl.kind = ecu_pkg::kind_t'(kind);
		ctl.lo = (t < ecu_pkg::HALF);
		ctl.neg = (t > ecu_pkg::HALF);
		ctl.zero = (t == '0);
		ctl.full = (t == ecu_pkg::ONE);

		case (ctl.kind)
			ecu_pkg::K_QUAD_OUT, ecu_pkg::K_CUBIC_OUT, ecu_pkg::K_BACK_OUT: begin
				sel_u = 1'b1;
			end
			ecu_pkg::K_QUAD_INOUT, ecu_pkg::K_CUBIC_INOUT: begin
				sel_u = !ctl.lo;
			end
			default: begin
				sel_u = 1'b0;
			end
		endcase
		v = sel_u ? u : t;
		x = (ctl.kind == ecu_pkg::K_QUAD_INOUT) ? (v << 1) : v;
		z = (ctl.kind == ecu_pkg::K_CUBIC_INOUT) ? (ecu_pkg::Z_W'(v) << 2)
			: ecu_pkg::Z_W'(v);

		// sine argument on the quarter wave
		case (ctl.kind)
			ecu_pkg::K_SINE_IN: begin
				sarg = u;
			end
			ecu_pkg::K_SINE_INOUT: begin
				sarg = ctl.neg ? ecu_pkg::T_W'(t2 - {1'b0, ecu_pkg::ONE})
					: ecu_pkg::T_W'({1'b0, ecu_pkg::ONE} - t2);
			end
			default: begin
				sarg = t;
			end
		endcase
		ctl.sfull = (sarg == ecu_pkg::ONE);

		earg = ecu_pkg::E_W'((ctl.kind == ecu_pkg::K_EXPO_IN) ? t : u)
			* ecu_pkg::E_W'(ecu_pkg::EXP_SCALE);

		// bounce: pick the parabola and its offset from its vertex
		t11 = ecu_pkg::B_W'(t) * ecu_pkg::B_W'(ecu_pkg::BOUNCE_MUL);
		t22 = t11 << 1;
		if (t11 < ones(4)) begin
			ctl.region = ecu_pkg::B_FIRST;
			bd = t11;
		end else if (t11 < ones(8)) begin
			ctl.region = ecu_pkg::B_SECOND;
			bd = absdiff(t11, ones(6));
		end else if (t11 < ones(10)) begin
			ctl.region = ecu_pkg::B_THIRD;
			bd = absdiff(t11, ones(9));
		end else begin
			ctl.region = ecu_pkg::B_TAIL;
			bd = absdiff(t22, ones(21));
		end
		dmag = ecu_pkg::D_W'(bd);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s1 <= t;
			x_s1 <= x;
			y_s1 <= v;
			z_s1 <= z;
			sarg_s1 <= sarg;
			earg_s1 <= earg;
			dmag_s1 <= dmag;
		end
	end

endmodule

@@ hdl/ecu_core.sv @@
// ecu_core: stages two to four, product chain, rom reads, interpolation,
// power-of-two shift and bounce parabola; uses ecu_pkg
module ecu_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  ecu_pkg::ctl_t                ctl_s1,
	input  logic [ecu_pkg::T_W-1:0]      t_s1,
	input  logic [ecu_pkg::T_W-1:0]      x_s1,
	input  logic [ecu_pkg::T_W-1:0]      y_s1,
	input  logic [ecu_pkg::Z_W-1:0]      z_s1,
	input  logic [ecu_pkg::T_W-1:0]      sarg_s1,
	input  logic [ecu_pkg::E_W-1:0]      earg_s1,
	input  logic [ecu_pkg::D_W-1:0]      dmag_s1,
	output ecu_pkg::ctl_t                ctl_s4,
	output logic [ecu_pkg::T_W-1:0]      t_s4,
	output logic [ecu_pkg::T_W-1:0]      p_s4,
	output logic [ecu_pkg::T_W-1:0]      q_s4,
	output logic [ecu_pkg::Z_W-1:0]      a_s4,
	output logic [ecu_pkg::Z_W-1:0]      b_s4,
	output logic [ecu_pkg::T_W-1:0]      s_s4,
	output logic [ecu_pkg::EXP_W-1:0]    xe_s4,
	output logic [ecu_pkg::T_W-1:0]      bv_s4
);

	localparam int F   = ecu_pkg::FRAC_BITS;
	localparam int P1W = 2 * ecu_pkg::T_W + 1;
	localparam int P2W = ecu_pkg::T_W + ecu_pkg::Z_W + 1;
	localparam int SQW = 2 * ecu_pkg::D_W + 1;
	localparam int CW  = 32 + ecu_pkg::T_W + 1;
	localparam int SHW = ecu_pkg::EXP_W + 1;

	// stage two
	logic [P1W-1:0]                prod1;
	logic [SQW-1:0]                sq;
	logic [SQW-1:0]                bsh;
	logic [ecu_pkg::T_W-1:0]       boff;
	logic [ecu_pkg::SINE_IDX_W:0]  sidx;
	logic [ecu_pkg::EXP_IDX_W:0]   eidx;
	logic [F-1:0]                  sfr, efr;
	ecu_pkg::ctl_t                 ctl_s2;
	logic [ecu_pkg::T_W-1:0]       t_s2, p_s2, sa_s2, sb_s2, bv_s2;
	logic [ecu_pkg::Z_W-1:0]       z_s2;
	logic [F-1:0]                  sfr_s2, efr_s2;
	logic [ecu_pkg::EXP_W-1:0]     ea_s2, eb_s2;
	logic [3:0]                    eip_s2;

	// stage three
	logic [P2W-1:0]                prod2;
	logic [CW-1:0]                 prod_a;
	logic [ecu_pkg::EXP_W-1:0]     sint;
	ecu_pkg::ctl_t                 ctl_s3;
	logic [ecu_pkg::T_W-1:0]       t_s3, p_s3, q_s3, s_s3, bv_s3;
	logic [ecu_pkg::Z_W-1:0]       a_s3;
	logic [ecu_pkg::EXP_W-1:0]     m_s3;
	logic [3:0]                    eip_s3;

	// stage four
	logic [CW-1:0]                 prod_b;
	logic [3:0]                    sh;
	logic [SHW-1:0]                msh;

	always_comb begin
		prod1 = P1W'(x_s1) * P1W'(y_s1) + (P1W'(1) << (F - 1));

		sidx = {1'b0, sarg_s1[F-1 -: ecu_pkg::SINE_IDX_W]};
		sfr = sarg_s1[F-1:0] << ecu_pkg::SINE_IDX_W;
		eidx = {1'b0, earg_s1[F-1 -: ecu_pkg::EXP_IDX_W]};
		efr = earg_s1[F-1:0] << ecu_pkg::EXP_IDX_W;

		sq = SQW'(dmag_s1) * SQW'(dmag_s1);
		case (ctl_s1.region)
			ecu_pkg::B_FIRST: begin
				bsh = (sq + (SQW'(1) << (F + 3))) >> (F + 4);
				boff = '0;
			end
			ecu_pkg::B_SECOND: begin
				bsh = (sq + (SQW'(1) << (F + 3))) >> (F + 4);
				boff = ecu_pkg::T_W'((3 * (1 << F)) / 4);
			end
			ecu_pkg::B_THIRD: begin
				bsh = (sq + (SQW'(1) << (F + 3))) >> (F + 4);
				boff = ecu_pkg::T_W'((15 * (1 << F)) / 16);
			end
			default: begin
				bsh = (sq + (SQW'(1) << (F + 5))) >> (F + 6);
				boff = ecu_pkg::T_W'((63 * (1 << F)) / 64);
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
		end else if (en) begin
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s2 <= t_s1;
			p_s2 <= ecu_pkg::T_W'(prod1 >> F);
			z_s2 <= z_s1;
			sa_s2 <= ecu_pkg::SINE_ROM[sidx];
			sb_s2 <= ecu_pkg::SINE_ROM[sidx + 1'b1];
			sfr_s2 <= sfr;
			ea_s2 <= ecu_pkg::EXP_ROM[eidx];
			eb_s2 <= ecu_pkg::EXP_ROM[eidx + 1'b1];
			efr_s2 <= efr;
			eip_s2 <= earg_s1[ecu_pkg::E_W-1:F];
			bv_s2 <= ecu_pkg::T_W'(bsh) + boff;
		end
	end

	always_comb begin
		prod2 = P2W'(p_s2) * P2W'(z_s2) + (P2W'(1) << (F - 1));
		prod_a = CW'(ecu_pkg::BACK_C1_Q30) * CW'(p_s2)
			+ (CW'(1) << (ecu_pkg::Q30_BITS - 1));
		sint = ecu_pkg::interp(ecu_pkg::EXP_W'(sa_s2), ecu_pkg::EXP_W'(sb_s2), sfr_s2);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s3 <= t_s2;
			p_s3 <= p_s2;
			q_s3 <= ecu_pkg::T_W'(prod2 >> F);
			a_s3 <= ecu_pkg::Z_W'(prod_a >> ecu_pkg::Q30_BITS);
			s_s3 <= ctl_s2.sfull ? ecu_pkg::ONE : ecu_pkg::T_W'(sint);
			m_s3 <= ecu_pkg::interp(ea_s2, eb_s2, efr_s2);
			eip_s3 <= eip_s2;
			bv_s3 <= bv_s2;
		end
	end

	always_comb begin
		prod_b = CW'(ecu_pkg::BACK_C3_Q30) * CW'(q_s3)
			+ (CW'(1) << (ecu_pkg::Q30_BITS - 1));
		sh = 4'(ecu_pkg::EXP_SCALE) - eip_s3;
		msh = (SHW'(m_s3) + (SHW'(1) << (sh - 4'd1))) >> sh;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s4 <= t_s3;
			p_s4 <= p_s3;
			q_s4 <= q_s3;
			a_s4 <= a_s3;
			b_s4 <= ecu_pkg::Z_W'(prod_b >> ecu_pkg::Q30_BITS);
			s_s4 <= s_s3;
			xe_s4 <= (eip_s3 >= 4'(ecu_pkg::EXP_SCALE)) ? m_s3 : ecu_pkg::EXP_W'(msh);
			bv_s4 <= bv_s3;
		end
	end

endmodule

@@ hdl/ecu_final.sv @@
// ecu_final: last stage, selects the curve result, clamps it and holds the
// output word; uses ecu_pkg
module ecu_final (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  ecu_pkg::ctl_t                ctl_s4,
	input  logic [ecu_pkg::T_W-1:0]      t_s4,
	input  logic [ecu_pkg::T_W-1:0]      p_s4,
	input  logic [ecu_pkg::T_W-1:0]      q_s4,
	input  logic [ecu_pkg::Z_W-1:0]      a_s4,
	input  logic [ecu_pkg::Z_W-1:0]      b_s4,
	input  logic [ecu_pkg::T_W-1:0]      s_s4,
	input  logic [ecu_pkg::EXP_W-1:0]    xe_s4,
	input  logic [ecu_pkg::T_W-1:0]      bv_s4,
	output logic                         valid_s5,
	output logic signed [ecu_pkg::OUT_W-1:0] eased_s5
);

	localparam logic signed [ecu_pkg::RES_W-1:0] ONE_R = ecu_pkg::RES_W'(ecu_pkg::ONE);
	localparam logic signed [ecu_pkg::RES_W-1:0] LSB_R = ecu_pkg::RES_W'(1);
	localparam logic signed [ecu_pkg::RES_W-1:0] MAX_R = (ONE_R <<< 1) - LSB_R;

	logic signed [ecu_pkg::RES_W-1:0] r, rc;

	function automatic logic signed [ecu_pkg::RES_W-1:0] ext(input logic [ecu_pkg::EXP_W-1:0] v);
		return $signed(ecu_pkg::RES_W'(v));
	endfunction

	function automatic logic signed [ecu_pkg::RES_W-1:0] extt(input logic [ecu_pkg::T_W-1:0] v);
		return $signed(ecu_pkg::RES_W'(v));
	endfunction

	always_comb begin
		case (ctl_s4.kind)
			ecu_pkg::K_LINEAR:      r = extt(t_s4);
			ecu_pkg::K_QUAD_IN:     r = extt(p_s4);
			ecu_pkg::K_QUAD_OUT:    r = ONE_R - extt(p_s4);
			ecu_pkg::K_QUAD_INOUT:  r = ctl_s4.lo ? extt(p_s4) : ONE_R - extt(p_s4);
			ecu_pkg::K_CUBIC_IN:    r = extt(q_s4);
			ecu_pkg::K_CUBIC_OUT:   r = ONE_R - extt(q_s4);
			ecu_pkg::K_CUBIC_INOUT: r = ctl_s4.lo ? extt(q_s4) : ONE_R - extt(q_s4);
			ecu_pkg::K_SINE_IN:     r = ONE_R - extt(s_s4);
			ecu_pkg::K_SINE_OUT:    r = extt(s_s4);
			ecu_pkg::K_SINE_INOUT: begin
				r = ctl_s4.neg ? ((ONE_R + extt(s_s4) + LSB_R) >>> 1)
					: ((ONE_R - extt(s_s4) + LSB_R) >>> 1);
			end
			ecu_pkg::K_EXPO_IN:     r = ctl_s4.zero ? '0 : ext(xe_s4);
			ecu_pkg::K_EXPO_OUT:    r = ctl_s4.full ? ONE_R : ONE_R - ext(xe_s4);
			ecu_pkg::K_BOUNCE_OUT:  r = extt(bv_s4);
			ecu_pkg::K_BACK_OUT:    r = ONE_R + ext(a_s4) - ext(b_s4);
			default:                r = '0;
		endcase
		if (r < -ONE_R) begin
			rc = -ONE_R;
		end else if (r > MAX_R) begin
			rc = MAX_R;
		end else begin
			rc = r;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s5 <= ctl_s4.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			eased_s5 <= ecu_pkg::OUT_W'(rc);
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(eased_s5) && $stable(valid_s5))
		else $error("output word moved while the pipe was held");

	a_sine_out: assert property (@(posedge clk) disable iff (!arst_n)
		en && ctl_s4.valid && ctl_s4.kind == ecu_pkg::K_SINE_OUT
		|=> eased_s5 >= 0 && eased_s5 <= $signed(ecu_pkg::OUT_W'(ecu_pkg::ONE)))
		else $error("sine out left the unit range");

	a_expo_zero: assert property (@(posedge clk) disable iff (!arst_n)
		en && ctl_s4.valid && ctl_s4.kind == ecu_pkg::K_EXPO_IN && ctl_s4.zero
		|=> eased_s5 == '0)
		else $error("expo in at zero progress not exactly zero");

	a_bad_kind: assert property (@(posedge clk) disable iff (!arst_n)
		en && ctl_s4.valid && ctl_s4.kind > ecu_pkg::K_BACK_OUT |=> eased_s5 == '0)
		else $error("undefined curve gave a non-zero word");

endmodule

@@ hdl/easing_curve_unit.sv @@
// easing_curve_unit: top level of the easing curve pipeline
// uses ecu_pkg, ecu_prep, ecu_core and ecu_final
//
//  channel | handshake            | word
//  --------+----------------------+------------------------------------------
//  in      | in_valid / in_stall  | kind (4 b curve code), progress (17 b t)
//  out     | out_valid / out_stall| eased (18 b signed, 1.0 = 65536)
//
// five register stages: operand prep, first product and rom reads, second
// product and interpolation, back-out constant product and exponent shift,
// result select and clamp into the output register
// one word in and one word out every cycle while the output is not stalled
// reset clears the valid bits of every stage; payload registers are not reset
// a stalled output word holds the whole pipe, so in_stall follows
// out_valid and out_stall; nothing is dropped or repeated
module easing_curve_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [3:0]                       kind,
	input  logic [ecu_pkg::T_W-1:0]          progress,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic signed [ecu_pkg::OUT_W-1:0] eased
);

	logic                        en;
	ecu_pkg::ctl_t               ctl_s1, ctl_s4;
	logic [ecu_pkg::T_W-1:0]     t_s1, x_s1, y_s1, sarg_s1;
	logic [ecu_pkg::Z_W-1:0]     z_s1;
	logic [ecu_pkg::E_W-1:0]     earg_s1;
	logic [ecu_pkg::D_W-1:0]     dmag_s1;
	logic [ecu_pkg::T_W-1:0]     t_s4, p_s4, q_s4, s_s4, bv_s4;
	logic [ecu_pkg::Z_W-1:0]     a_s4, b_s4;
	logic [ecu_pkg::EXP_W-1:0]   xe_s4;

	// the pipe moves unless a finished word waits on a stalled consumer
	assign en = !(out_valid && out_stall);
	assign in_stall = !en;

	ecu_prep u_prep (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (in_valid),
		.kind     (kind),
		.progress (progress),
		.ctl_s1   (ctl_s1),
		.t_s1     (t_s1),
		.x_s1     (x_s1),
		.y_s1     (y_s1),
		.z_s1     (z_s1),
		.sarg_s1  (sarg_s1),
		.earg_s1  (earg_s1),
		.dmag_s1  (dmag_s1)
	);

	// products, rom lookups and interpolation
	ecu_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.ctl_s1  (ctl_s1),
		.t_s1    (t_s1),
		.x_s1    (x_s1),
		.y_s1    (y_s1),
		.z_s1    (z_s1),
		.sarg_s1 (sarg_s1),
		.earg_s1 (earg_s1),
		.dmag_s1 (dmag_s1),
		.ctl_s4  (ctl_s4),
		.t_s4    (t_s4),
		.p_s4    (p_s4),
		.q_s4    (q_s4),
		.a_s4    (a_s4),
		.b_s4    (b_s4),
		.s_s4    (s_s4),
		.xe_s4   (xe_s4),
		.bv_s4   (bv_s4)
	);

	// curve select and clamp, output register
	ecu_final u_final (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.ctl_s4   (ctl_s4),
		.t_s4     (t_s4),
		.p_s4     (p_s4),
		.q_s4     (q_s4),
		.a_s4     (a_s4),
		.b_s4     (b_s4),
		.s_s4     (s_s4),
		.xe_s4    (xe_s4),
		.bv_s4    (bv_s4),
		.valid_s5 (out_valid),
		.eased_s5 (eased)
	);

endmodule
